/* design/acds_pkg.sv */
// Package for the AABB push-out summing block: item and box types, opcodes,
// and the per-axis push arithmetic shared by the cells. No dependencies.
package acds_pkg;

  localparam int unsigned CoordW = 16;
  localparam int unsigned PushW  = 17;
  localparam int unsigned SumW   = 20;
  localparam int unsigned IdxW   = 3;
  localparam int unsigned CntW   = 4;

  typedef enum logic [0:0] {
    OP_WRITE = 1'b0,
    OP_QUERY = 1'b1
  } acds_op_e;

  typedef struct packed {
    logic signed [CoordW-1:0] min_x;
    logic signed [CoordW-1:0] min_y;
    logic signed [CoordW-1:0] max_x;
    logic signed [CoordW-1:0] max_y;
  } acds_box_t;

  typedef struct packed {
    acds_op_e                op;
    logic [IdxW-1:0]         idx;
    acds_box_t               box;
    logic signed [SumW-1:0]  sum_x;
    logic signed [SumW-1:0]  sum_y;
  } acds_item_t;

  function automatic logic [PushW-1:0] push_mag(input logic signed [PushW-1:0] v);
    return v[PushW-1] ? PushW'(-v) : PushW'(v);
  endfunction

  // Smaller-magnitude push on one axis; a tie keeps the right push.
  function automatic logic signed [PushW-1:0] axis_push(
    input logic signed [CoordW-1:0] s_min,
    input logic signed [CoordW-1:0] s_max,
    input logic signed [CoordW-1:0] m_min,
    input logic signed [CoordW-1:0] m_max
  );
    logic signed [PushW-1:0] right;
    logic signed [PushW-1:0] left;
    right = {s_max[CoordW-1], s_max} - {m_min[CoordW-1], m_min};
    left  = {s_min[CoordW-1], s_min} - {m_max[CoordW-1], m_max};
    return (push_mag(right) > push_mag(left)) ? left : right;
  endfunction

endpackage

/* design/acds_if.sv */
// Valid/ready channel interfaces for the AABB push-out summing block.
// Input carries write and query transactions, output carries summed pushes.
interface acds_in_if;
  logic               valid;
  logic               ready;
  logic               opcode;
  logic [2:0]         entry_index;
  logic signed [15:0] box_min_x;
  logic signed [15:0] box_min_y;
  logic signed [15:0] box_max_x;
  logic signed [15:0] box_max_y;

  modport source (output valid, opcode, entry_index, box_min_x, box_min_y,
                  box_max_x, box_max_y, input ready);
  modport sink   (input valid, opcode, entry_index, box_min_x, box_min_y,
                  box_max_x, box_max_y, output ready);
endinterface

interface acds_out_if;
  logic               valid;
  logic               ready;
  logic signed [19:0] push_x;
  logic signed [19:0] push_y;

  modport source (output valid, push_x, push_y, input ready);
  modport sink   (input valid, push_x, push_y, output ready);
endinterface

/* design/acds_cell.sv */
// One cell of the box chain: holds one static box and adds its push-out to
// the passing query's running sums over two register stages. Uses acds_pkg.
module acds_cell #(
  parameter int unsigned CELL_IDX = 0
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  en_i,
  input  logic [3:0]            active_i,
  input  logic                  valid_i,
  input  acds_pkg::acds_item_t  item_i,
  output logic                  valid_o,
  output acds_pkg::acds_item_t  item_o
);
  import acds_pkg::*;

  acds_box_t               box_q;
  logic                    valid_a_q;
  acds_item_t              item_a_q;
  logic                    hit_a_q;
  logic signed [PushW-1:0] px_a_q;
  logic signed [PushW-1:0] py_a_q;
  logic                    valid_b_q;
  acds_item_t              item_b_q;

  logic                    overlap;
  logic                    hit_d;
  acds_item_t              item_b_d;

  // Capture the static box when a write for this slot passes by.
  always_ff @(posedge clk_i) begin
    if (en_i && valid_i && item_i.op == OP_WRITE && item_i.idx == IdxW'(CELL_IDX)) begin
      box_q <= item_i.box;
    end
  end

  always_comb begin
    overlap = (item_i.box.min_x <= box_q.max_x) && (item_i.box.max_x >= box_q.min_x) &&
              (item_i.box.min_y <= box_q.max_y) && (item_i.box.max_y >= box_q.min_y);
    hit_d   = overlap && item_i.op == OP_QUERY && (active_i > CntW'(CELL_IDX));
  end

  always_comb begin
    item_b_d = item_a_q;
    if (hit_a_q) begin
      // Keep only the smaller axis; a tie keeps x.
      if (push_mag(px_a_q) > push_mag(py_a_q)) begin
        item_b_d.sum_y = item_a_q.sum_y + SumW'(py_a_q);
      end else begin
        item_b_d.sum_x = item_a_q.sum_x + SumW'(px_a_q);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_a_q <= 1'b0;
      valid_b_q <= 1'b0;
    end else if (en_i) begin
      valid_a_q <= valid_i;
      valid_b_q <= valid_a_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      item_a_q <= item_i;
      hit_a_q  <= hit_d;
      px_a_q   <= axis_push(box_q.min_x, box_q.max_x, item_i.box.min_x, item_i.box.max_x);
      py_a_q   <= axis_push(box_q.min_y, box_q.max_y, item_i.box.min_y, item_i.box.max_y);
      item_b_q <= item_b_d;
    end
  end

  assign valid_o = valid_b_q;
  assign item_o  = item_b_q;

endmodule

/* design/aabb_collision_displacement_sum_top.sv */
// AABB push-out sum: a chain of NUM_BOXES cells, each holding one static box.
// A query's transaction is registered into the first cell's first stage at the edge that accepts
// it, then passes two register stages per cell and finally the output register.
// Throughput: one transaction per cycle; the whole chain holds while a result
// waits untaken in the output register. Writes travel the chain in order.
// Reset (rst_ni low, async) clears valid bits and active_boxes; the box table has no reset.
module aabb_collision_displacement_sum_top #(
  parameter int unsigned NUM_BOXES = 8
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic [3:0] cfg_wdata_i,
  acds_in_if.sink    in_i,
  acds_out_if.source out_o
);
  import acds_pkg::*;

  // Chain taps: tap 0 is the input transaction, tap NUM_BOXES the last cell.
  logic       valid_c [NUM_BOXES+1];
  acds_item_t item_c  [NUM_BOXES+1];

  logic [CntW-1:0]        active_boxes_q;
  logic                   out_valid_q;
  logic signed [SumW-1:0] push_x_q;
  logic signed [SumW-1:0] push_y_q;
  logic                   en;

  // Advance the chain whenever the output register is free or being drained.
  assign en         = !out_valid_q || out_o.ready;
  assign in_i.ready = en;

  // Feed the head of the chain with zeroed running sums.
  assign valid_c[0]          = in_i.valid;
  assign item_c[0].op        = acds_op_e'(in_i.opcode);
  assign item_c[0].idx       = in_i.entry_index;
  assign item_c[0].box.min_x = in_i.box_min_x;
  assign item_c[0].box.min_y = in_i.box_min_y;
  assign item_c[0].box.max_x = in_i.box_max_x;
  assign item_c[0].box.max_y = in_i.box_max_y;
  assign item_c[0].sum_x     = '0;
  assign item_c[0].sum_y     = '0;

  for (genvar g = 0; g < NUM_BOXES; g++) begin : g_cell
    acds_cell #(
      .CELL_IDX (g)
    ) u_cell (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .en_i     (en),
      .active_i (active_boxes_q),
      .valid_i  (valid_c[g]),
      .item_i   (item_c[g]),
      .valid_o  (valid_c[g+1]),
      .item_o   (item_c[g+1])
    );
  end

  // Configuration: the number of active boxes. Counts above NUM_BOXES simply
  // enable every cell.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_boxes_q <= '0;
    end else if (cfg_we_i) begin
      active_boxes_q <= cfg_wdata_i;
    end
  end

  // Output register: take queries leaving the chain, drop writes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= valid_c[NUM_BOXES] && item_c[NUM_BOXES].op == OP_QUERY;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      push_x_q <= item_c[NUM_BOXES].sum_x;
      push_y_q <= item_c[NUM_BOXES].sum_y;
    end
  end

  assign out_o.valid  = out_valid_q;
  assign out_o.push_x = push_x_q;
  assign out_o.push_y = push_y_q;

endmodule

/* design/acds_checker.sv */
// Port-level checker for the AABB push-out summing block, bound to the top.
// Tracks queries in flight; observes only the top level's ports and uses acds_pkg.
module acds_checker #(
  parameter int unsigned NUM_BOXES = 8
) (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_ready_i,
  input logic               in_opcode_i,
  input logic               out_valid_i,
  input logic               out_ready_i,
  input logic signed [19:0] out_push_x_i,
  input logic signed [19:0] out_push_y_i
);
  import acds_pkg::*;

  localparam int unsigned PendW = $clog2(2 * NUM_BOXES + 3);

  logic [PendW-1:0] pending_q;
  logic             q_in;
  logic             q_out;

  assign q_in  = in_valid_i && in_ready_i && in_opcode_i == OP_QUERY;
  assign q_out = out_valid_i && out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pending_q <= '0;
    end else if (q_in && !q_out) begin
      pending_q <= pending_q + PendW'(1);
    end else if (!q_in && q_out) begin
      pending_q <= pending_q - PendW'(1);
    end
  end

  a_out_valid_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result dropped while stalled");

  a_out_data_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> $stable(out_push_x_i) && $stable(out_push_y_i))
    else $error("result changed while stalled");

  a_result_has_query: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> pending_q != '0)
    else $error("result without a pending query");

  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_i |-> in_ready_i)
    else $error("input stalled with empty output register");

endmodule

bind aabb_collision_displacement_sum_top acds_checker #(
  .NUM_BOXES (NUM_BOXES)
) u_acds_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_i.valid),
  .in_ready_i   (in_i.ready),
  .in_opcode_i  (in_i.opcode),
  .out_valid_i  (out_o.valid),
  .out_ready_i  (out_o.ready),
  .out_push_x_i (out_o.push_x),
  .out_push_y_i (out_o.push_y)
);
